@@ rtl/core/srkl_pkg.sv @@
// Package: shared types, status codes and sizes for the sorted run key lookup.
`default_nettype none
package srkl_pkg;

  localparam int ENTRIES = 4096;
  localparam int ADDR_W  = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  localparam logic       OP_LOAD   = 1'b0;
  localparam logic       OP_LOOKUP = 1'b1;

  localparam logic [2:0] ST_LOADED = 3'd0;
  localparam logic [2:0] ST_STALE  = 3'd1;
  localparam logic [2:0] ST_RANGE  = 3'd2;
  localparam logic [2:0] ST_MISS   = 3'd3;
  localparam logic [2:0] ST_FOUND  = 3'd4;

  localparam logic [2:0] REG_TABLE_TS  = 3'd0;
  localparam logic [2:0] REG_SMALLEST  = 3'd1;
  localparam logic [2:0] REG_LARGEST   = 3'd2;
  localparam logic [2:0] REG_COUNT     = 3'd3;
  localparam logic [2:0] REG_DATA_END  = 3'd4;

  typedef struct packed {
    logic        operation;
    logic [11:0] entry_index;
    logic [63:0] item_key;
    logic [31:0] entry_offset;
    logic [63:0] best_timestamp;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] value_offset;
    logic [31:0] value_length;
    logic [63:0] new_timestamp;
  } out_item_t;

  typedef struct packed {
    logic [63:0] table_timestamp;
    logic [63:0] smallest_key;
    logic [63:0] largest_key;
    logic [12:0] entry_count;
    logic [31:0] data_end_offset;
  } cfg_t;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [63:0]       wr_key;
    logic [31:0]       wr_offset;
    logic              key_rd_en;
    logic [ADDR_W-1:0] key_rd_addr;
    logic              off_rd_en;
    logic [ADDR_W-1:0] off_rd_addr;
  } store_req_t;

  // Probe point of the half-open window [low, hix); caller guarantees low < hix.
  function automatic logic [ADDR_W-1:0] probe_mid(input logic [CNT_W-1:0] low,
                                                  input logic [CNT_W-1:0] hix);
    logic [CNT_W-1:0] span;
    logic [CNT_W-1:0] mid;
    span = hix - low - CNT_W'(1);
    mid  = low + (span >> 1);
    return ADDR_W'(mid);
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/sorted_run_key_lookup_core.sv @@
// Top level: configuration registers, search sequencer and entry memories.
//
//   channel  ports                                   transfer
//   input    start, busy, in_item                    start && !busy
//   result   out_valid, out_item                     out_valid, one cycle
//   config   cfg_valid, cfg_ready, cfg_index, cfg_data  cfg_valid && cfg_ready
//
// A load writes both memories at its accept edge; its result follows in the next
// cycle and busy stays low, so loads can issue every cycle.
// A lookup makes one key memory read per probe (at most 13 probes for 4096
// entries) and, on a hit, one or two offset reads for the value length.
// busy drops in the cycle the result appears. Reset is synchronous on rst_n and
// clears control and configuration; the memories are not cleared.
// Results are never held back: out_valid lasts exactly one cycle.
`default_nettype none
module sorted_run_key_lookup_core (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire srkl_pkg::in_item_t   in_item,
  output logic                      out_valid,
  output srkl_pkg::out_item_t       out_item,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [2:0]           cfg_index,
  input  wire logic [63:0]          cfg_data
);

  srkl_pkg::cfg_t       cfg_r, cfg_nxt;
  srkl_pkg::store_req_t req;
  logic [63:0]          key_rd_data;
  logic [31:0]          off_rd_data;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        srkl_pkg::REG_TABLE_TS: cfg_nxt.table_timestamp = cfg_data;
        srkl_pkg::REG_SMALLEST: cfg_nxt.smallest_key    = cfg_data;
        srkl_pkg::REG_LARGEST:  cfg_nxt.largest_key     = cfg_data;
        srkl_pkg::REG_COUNT:    cfg_nxt.entry_count     = cfg_data[12:0];
        srkl_pkg::REG_DATA_END: cfg_nxt.data_end_offset = cfg_data[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  srkl_search u_search (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_item     (in_item),
    .cfg         (cfg_r),
    .busy        (busy),
    .req         (req),
    .key_rd_data (key_rd_data),
    .off_rd_data (off_rd_data),
    .out_valid   (out_valid),
    .out_item    (out_item)
  );

  srkl_store u_store (
    .clk         (clk),
    .req         (req),
    .key_rd_data (key_rd_data),
    .off_rd_data (off_rd_data)
  );

endmodule
`default_nettype wire

@@ rtl/core/srkl_store.sv @@
// Key and offset memories: one write port, one registered read port each.
`default_nettype none
module srkl_store (
  input  wire logic                 clk,
  input  wire srkl_pkg::store_req_t req,
  output logic [63:0]               key_rd_data,
  output logic [31:0]               off_rd_data
);

  logic [63:0] key_mem [srkl_pkg::ENTRIES];
  logic [31:0] off_mem [srkl_pkg::ENTRIES];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      key_mem[req.wr_addr] <= req.wr_key;
    end
    if (req.key_rd_en) begin
      key_rd_data <= key_mem[req.key_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      off_mem[req.wr_addr] <= req.wr_offset;
    end
    if (req.off_rd_en) begin
      off_rd_data <= off_mem[req.off_rd_addr];
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/srkl_search.sv @@
// Sequencer: load writes, stale and range checks, binary search, length fetch.
`default_nettype none
module srkl_search (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire srkl_pkg::in_item_t        in_item,
  input  wire srkl_pkg::cfg_t            cfg,
  output logic                           busy,
  output srkl_pkg::store_req_t           req,
  input  wire logic [63:0]               key_rd_data,
  input  wire logic [31:0]               off_rd_data,
  output logic                           out_valid,
  output srkl_pkg::out_item_t            out_item
);

  localparam int AW = srkl_pkg::ADDR_W;
  localparam int CW = srkl_pkg::CNT_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_CMP   = 3'd2;
  localparam logic [2:0] S_OFF0  = 3'd3;
  localparam logic [2:0] S_OFF1  = 3'd4;

  logic [2:0]          state_r, state_nxt;
  logic [63:0]         key_r, key_nxt;
  logic [63:0]         best_r, best_nxt;
  logic [CW-1:0]       low_r, low_nxt;
  logic [CW-1:0]       hix_r, hix_nxt;
  logic [AW-1:0]       mid_r, mid_nxt;
  logic [31:0]         beg_r, beg_nxt;
  logic                out_valid_r, out_valid_nxt;
  srkl_pkg::out_item_t out_item_r, out_item_nxt;

  logic [CW-1:0] cnt;
  logic [CW-1:0] low_step;
  logic [CW-1:0] hix_step;

  assign cnt = (cfg.entry_count > CW'(srkl_pkg::ENTRIES)) ? CW'(srkl_pkg::ENTRIES)
                                                          : CW'(cfg.entry_count);

  // Narrowed window after a probe that did not match
  assign low_step = (key_rd_data > key_r) ? low_r : (CW'(mid_r) + CW'(1));
  assign hix_step = (key_rd_data > key_r) ? CW'(mid_r) : hix_r;

  always_comb begin
    state_nxt     = state_r;
    key_nxt       = key_r;
    best_nxt      = best_r;
    low_nxt       = low_r;
    hix_nxt       = hix_r;
    mid_nxt       = mid_r;
    beg_nxt       = beg_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    req           = '0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          key_nxt  = in_item.item_key;
          best_nxt = in_item.best_timestamp;
          if (in_item.operation == srkl_pkg::OP_LOAD) begin
            req.wr_en     = (32'(in_item.entry_index) < 32'(srkl_pkg::ENTRIES));
            req.wr_addr   = AW'(in_item.entry_index);
            req.wr_key    = in_item.item_key;
            req.wr_offset = in_item.entry_offset;
            out_valid_nxt = 1'b1;
            out_item_nxt  = '{status: srkl_pkg::ST_LOADED, value_offset: 32'd0,
                              value_length: 32'd0,
                              new_timestamp: in_item.best_timestamp};
          end else begin
            state_nxt = S_CHECK;
          end
        end
      end

      S_CHECK: begin
        out_item_nxt = '{status: srkl_pkg::ST_MISS, value_offset: 32'd0,
                         value_length: 32'd0, new_timestamp: best_r};
        priority if (cfg.table_timestamp <= best_r) begin
          out_item_nxt.status = srkl_pkg::ST_STALE;
          out_valid_nxt       = 1'b1;
          state_nxt           = S_IDLE;
        end else if (key_r > cfg.largest_key || key_r < cfg.smallest_key) begin
          out_item_nxt.status = srkl_pkg::ST_RANGE;
          out_valid_nxt       = 1'b1;
          state_nxt           = S_IDLE;
        end else if (cnt == '0) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          low_nxt         = '0;
          hix_nxt         = cnt;
          mid_nxt         = srkl_pkg::probe_mid('0, cnt);
          req.key_rd_en   = 1'b1;
          req.key_rd_addr = srkl_pkg::probe_mid('0, cnt);
          state_nxt       = S_CMP;
        end
      end

      S_CMP: begin
        if (key_rd_data == key_r) begin
          req.off_rd_en   = 1'b1;
          req.off_rd_addr = mid_r;
          state_nxt       = S_OFF0;
        end else if (low_step < hix_step) begin
          low_nxt         = low_step;
          hix_nxt         = hix_step;
          mid_nxt         = srkl_pkg::probe_mid(low_step, hix_step);
          req.key_rd_en   = 1'b1;
          req.key_rd_addr = srkl_pkg::probe_mid(low_step, hix_step);
        end else begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      S_OFF0: begin
        beg_nxt = off_rd_data;
        if ((CW'(mid_r) + CW'(1)) == cnt) begin
          out_item_nxt  = '{status: srkl_pkg::ST_FOUND, value_offset: off_rd_data,
                            value_length: cfg.data_end_offset - off_rd_data,
                            new_timestamp: cfg.table_timestamp};
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          req.off_rd_en   = 1'b1;
          req.off_rd_addr = mid_r + AW'(1);
          state_nxt       = S_OFF1;
        end
      end

      S_OFF1: begin
        out_item_nxt  = '{status: srkl_pkg::ST_FOUND, value_offset: beg_r,
                          value_length: off_rd_data - beg_r,
                          new_timestamp: cfg.table_timestamp};
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r      <= key_nxt;
    best_r     <= best_nxt;
    low_r      <= low_nxt;
    hix_r      <= hix_nxt;
    mid_r      <= mid_nxt;
    beg_r      <= beg_nxt;
    out_item_r <= out_item_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
`default_nettype wire

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the sorted run key lookup core: loads, lookups, register programming.
module testbench;
  import srkl_pkg::*;

  localparam int          CYCLE_LIMIT = 1_000_000;
  localparam int          MAX_REPORTS = 10;
  localparam logic [63:0] KEY_MAX     = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] FULL_STRIDE = 64'd16;

  class lookup_scoreboard;
    cfg_t        regs;
    logic [63:0] key_mem [ENTRIES];
    logic [31:0] off_mem [ENTRIES];
    out_item_t   pending_answers [$];
    int          error_count;

    function new();
      regs        = '0;
      error_count = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [63:0] data);
      case (idx)
        REG_TABLE_TS: regs.table_timestamp = data;
        REG_SMALLEST: regs.smallest_key    = data;
        REG_LARGEST:  regs.largest_key     = data;
        REG_COUNT:    regs.entry_count     = data[12:0];
        REG_DATA_END: regs.data_end_offset = data[31:0];
        default: ;
      endcase
    endfunction

    function out_item_t compute_answer(in_item_t item);
      out_item_t   ans;
      int          cnt, lo, hi, mid, hit;
      logic [31:0] end_off;
      ans               = '0;
      ans.new_timestamp = item.best_timestamp;
      if (item.operation == OP_LOAD) begin
        if (item.entry_index < ENTRIES) begin
          key_mem[item.entry_index] = item.item_key;
          off_mem[item.entry_index] = item.entry_offset;
        end
        ans.status = ST_LOADED;
        return ans;
      end
      if (regs.table_timestamp <= item.best_timestamp) begin
        ans.status = ST_STALE;
        return ans;
      end
      if (item.item_key > regs.largest_key || item.item_key < regs.smallest_key) begin
        ans.status = ST_RANGE;
        return ans;
      end
      cnt = (regs.entry_count > ENTRIES) ? ENTRIES : int'(regs.entry_count);
      lo  = 0;
      hi  = cnt - 1;
      hit = -1;
      while (lo <= hi && hit < 0) begin
        mid = lo + (hi - lo) / 2;
        if (key_mem[mid] == item.item_key) hit = mid;
        else if (key_mem[mid] > item.item_key) hi = mid - 1;
        else lo = mid + 1;
      end
      if (hit < 0) begin
        ans.status = ST_MISS;
        return ans;
      end
      // last entry ends at the data end, others at the next entry's offset
      end_off           = (hit == cnt - 1) ? regs.data_end_offset : off_mem[hit + 1];
      ans.status        = ST_FOUND;
      ans.value_offset  = off_mem[hit];
      ans.value_length  = end_off - off_mem[hit];
      ans.new_timestamp = regs.table_timestamp;
      return ans;
    endfunction

    function void note_request(in_item_t item);
      pending_answers = {pending_answers, compute_answer(item)};
    endfunction

    function void flag(string field, logic [63:0] want, logic [63:0] got);
      error_count++;
      if (error_count <= MAX_REPORTS)
        $display("mismatch on %s: expected %h, got %h", field, want, got);
    endfunction

    function void check_answer(out_item_t got);
      out_item_t want;
      if (pending_answers.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("result with nothing pending: status %0d, timestamp %h",
                   got.status, got.new_timestamp);
        return;
      end
      want = pending_answers.pop_front();
      if (got.status !== want.status) flag("status", want.status, got.status);
      if (got.value_offset !== want.value_offset)
        flag("value_offset", want.value_offset, got.value_offset);
      if (got.value_length !== want.value_length)
        flag("value_length", want.value_length, got.value_length);
      if (got.new_timestamp !== want.new_timestamp)
        flag("new_timestamp", want.new_timestamp, got.new_timestamp);
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_item_t    in_item;
  logic        out_valid;
  out_item_t   out_item;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;

  lookup_scoreboard sb;
  bit               no_idle;
  int               cycle_count;
  logic [63:0]      run_keys [ENTRIES];
  logic [31:0]      run_offs [ENTRIES];

  sorted_run_key_lookup_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // every transaction is observed here, results checked before new requests are noted
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check_answer(out_item);
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (start && !busy) sb.note_request(in_item);
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // evenly spaced run over every slot of the store
  function automatic logic [63:0] full_key(logic [63:0] base, int i);
    return base + FULL_STRIDE * 64'(i);
  endfunction

  task automatic send_item(in_item_t item);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start   <= 1'b1;
    in_item <= item;
    do @(posedge clk); while (busy);
  endtask

  task automatic load_entry(int idx, logic [63:0] key, logic [31:0] off);
    in_item_t item;
    item.operation      = OP_LOAD;
    item.entry_index    = idx[11:0];
    item.item_key       = key;
    item.entry_offset   = off;
    item.best_timestamp = rand64();
    send_item(item);
  endtask

  task automatic query_key(logic [63:0] key, logic [63:0] best);
    in_item_t item;
    item.operation      = OP_LOOKUP;
    item.entry_index    = 12'($urandom);
    item.item_key       = key;
    item.entry_offset   = $urandom;
    item.best_timestamp = best;
    send_item(item);
  endtask

  task automatic wait_until_drained();
    @(negedge clk);
    start <= 1'b0;
    do @(posedge clk); while (sb.pending_answers.size() != 0 || busy);
  endtask

  task automatic write_reg_port(logic [2:0] idx, logic [63:0] data);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    @(negedge clk);
    if (gap > 0) begin
      cfg_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic program_run(input logic [63:0] ts, sk, lk, input logic [12:0] cnt,
                             input logic [31:0] dend);
    logic [63:0] cnt_word, end_word;
    // junk above the register width must be dropped
    cnt_word        = rand64();
    cnt_word[12:0]  = cnt;
    end_word        = rand64();
    end_word[31:0]  = dend;
    write_reg_port(REG_TABLE_TS, ts);
    write_reg_port(REG_SMALLEST, sk);
    write_reg_port(REG_LARGEST, lk);
    write_reg_port(REG_COUNT, cnt_word);
    write_reg_port(REG_DATA_END, end_word);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_sorted_run(int n);
    logic [63:0] k, step, shift;
    logic [31:0] off;
    bit          to_top, jumbled;
    int          order [];
    int          j, t;
    to_top  = ($urandom_range(0, 3) == 0);
    jumbled = ($urandom_range(0, 4) == 0);
    case ($urandom_range(0, 2))
      0:       step = 64'd4;
      1:       step = 64'd1000;
      default: step = 64'd1 << 20;
    endcase
    k   = to_top ? 64'd0 : rand64() >> (1 + $urandom_range(0, 40));
    off = $urandom;
    for (int i = 0; i < n; i++) begin
      run_keys[i] = k;
      run_offs[i] = off;
      k   = k + 1 + $urandom_range(0, int'(step) - 1);
      off = jumbled ? $urandom : off + $urandom_range(0, 5000);
    end
    // slide the run up so its last key is the largest possible key
    if (to_top) begin
      shift = ~run_keys[n-1];
      for (int i = 0; i < n; i++) run_keys[i] = run_keys[i] + shift;
    end
    order = new[n];
    for (int i = 0; i < n; i++) order[i] = i;
    for (int i = n - 1; i > 0; i--) begin
      j        = $urandom_range(0, i);
      t        = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    for (int i = 0; i < n; i++) load_entry(order[i], run_keys[order[i]], run_offs[order[i]]);
  endtask

  task automatic pick_timestamp(output logic [63:0] ts);
    case ($urandom_range(0, 5))
      0:       ts = KEY_MAX;
      1:       ts = 64'd1;
      default: ts = rand64();
    endcase
  endtask

  task automatic pick_best(input logic [63:0] ts, output logic [63:0] best);
    int r;
    r = $urandom_range(0, 99);
    if (r < 75 && ts != 64'd0) best = rand64() % ts;
    else if (r < 85) best = ts;
    else best = rand64();
  endtask

  // count at or above the store size: only the slots a search can reach get loaded
  task automatic run_full_phase(int cnt);
    logic [63:0] base, ts, sk, lk, key, best;
    logic [31:0] obase, dend;
    logic [63:0] queries [16];
    bit          on_path [ENTRIES];
    int          lo, hi, mid, r, nq;
    bit          done;
    no_idle = ($urandom_range(0, 3) == 0);
    base    = ($urandom_range(0, 3) == 0) ? KEY_MAX - FULL_STRIDE * 64'(ENTRIES - 1)
                                          : rand64() >> 2;
    obase   = $urandom;
    nq      = $urandom_range(6, 9);
    for (int i = 0; i < nq; i++) begin
      r = $urandom_range(0, 99);
      if (r < 50) key = full_key(base, $urandom_range(0, ENTRIES - 1));
      else if (r < 60) key = $urandom_range(0, 1) ? full_key(base, 0)
                                                  : full_key(base, ENTRIES - 1);
      else if (r < 75) key = full_key(base, $urandom_range(0, ENTRIES - 1)) + 64'd1;
      else if (r < 85) key = $urandom_range(0, 1) ? base - 64'd1
                                                  : full_key(base, ENTRIES - 1) + 64'd1;
      else key = rand64();
      queries[i] = key;
      lo   = 0;
      hi   = ENTRIES - 1;
      done = 1'b0;
      while (lo <= hi && !done) begin
        mid          = lo + (hi - lo) / 2;
        on_path[mid] = 1'b1;
        if (full_key(base, mid) == key) begin
          if (mid < ENTRIES - 1) on_path[mid + 1] = 1'b1;
          done = 1'b1;
        end else if (full_key(base, mid) > key) begin
          hi = mid - 1;
        end else begin
          lo = mid + 1;
        end
      end
    end
    for (int i = 0; i < ENTRIES; i++)
      if (on_path[i]) load_entry(i, full_key(base, i), obase + 32'(i) * 32'd100);
    wait_until_drained();
    pick_timestamp(ts);
    case ($urandom_range(0, 2))
      0: begin
        sk = full_key(base, 0);
        lk = full_key(base, ENTRIES - 1);
      end
      1: begin
        sk = 64'd0;
        lk = KEY_MAX;
      end
      default: begin
        sk = full_key(base, 0);
        lk = full_key(base, ENTRIES / 2);
      end
    endcase
    case ($urandom_range(0, 2))
      0:       dend = 32'd0;
      default: dend = obase + 32'(ENTRIES - 1) * 32'd100 + $urandom_range(0, 5000);
    endcase
    program_run(ts, sk, lk, 13'(cnt), dend);
    for (int i = 0; i < nq; i++) begin
      if ($urandom_range(0, 99) < 10) wait_until_drained();
      pick_best(ts, best);
      query_key(queries[i], best);
    end
    wait_until_drained();
  endtask

  task automatic run_phase(int p);
    int          cnt, n, nlook, idx, r;
    logic [63:0] ts, sk, lk, key, best, pad;
    logic [31:0] dend;
    case (p)
      2:       cnt = 0;
      default: cnt = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
    endcase
    n       = (cnt > ENTRIES) ? ENTRIES : cnt;
    no_idle = ($urandom_range(0, 3) == 0);
    if (n > 0) load_sorted_run(n);
    wait_until_drained();
    pick_timestamp(ts);
    if (n == 0) begin
      sk = 64'd0;
      lk = KEY_MAX;
    end else begin
      case ($urandom_range(0, 3))
        0: begin
          sk = run_keys[0];
          lk = run_keys[n-1];
        end
        1: begin
          sk = 64'd0;
          lk = KEY_MAX;
        end
        2: begin
          sk = run_keys[0];
          lk = run_keys[n/2];
        end
        default: begin
          pad = $urandom_range(0, 50);
          sk  = (run_keys[0] > pad) ? run_keys[0] - pad : 64'd0;
          lk  = (KEY_MAX - run_keys[n-1] > pad) ? run_keys[n-1] + pad : KEY_MAX;
        end
      endcase
    end
    case ($urandom_range(0, 3))
      0:       dend = 32'd0;
      1:       dend = 32'hFFFF_FFFF;
      default: dend = (n > 0) ? run_offs[n-1] + $urandom_range(0, 5000) : $urandom;
    endcase
    program_run(ts, sk, lk, 13'(cnt), dend);
    nlook = $urandom_range(20, 35);
    for (int i = 0; i < nlook; i++) begin
      if ($urandom_range(0, 99) < 4) wait_until_drained();
      if ($urandom_range(0, 99) < 8) begin
        // stray load: rewrites a slot in use (often with its own key) or one outside the run
        idx = $urandom_range(0, ENTRIES - 1);
        key = (idx < n && $urandom_range(0, 2) != 0) ? sb.key_mem[idx] : rand64();
        load_entry(idx, key, $urandom);
      end else begin
        r = $urandom_range(0, 99);
        if (n > 0 && r < 50) begin
          key = sb.key_mem[$urandom_range(0, n - 1)];
        end else if (n > 0 && r < 65) begin
          key = sb.key_mem[$urandom_range(0, n - 1)];
          key = $urandom_range(0, 1) ? key + 64'd1 : key - 64'd1;
        end else if (r < 80) begin
          key = $urandom_range(0, 1) ? sk - 64'd1 : lk + 64'd1;
        end else begin
          key = rand64();
        end
        pick_best(ts, best);
        query_key(key, best);
      end
    end
    wait_until_drained();
  endtask

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** sorted_run_key_lookup_core: FAILED **");
    $finish;
  end

  initial begin
    sb        = new();
    no_idle   = 1'b0;
    rst_n     = 1'b0;
    start     = 1'b0;
    in_item   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // registers at reset: table timestamp zero makes every lookup stale
    query_key(64'd0, 64'd0);
    wait_until_drained();
    for (int k = 1; k <= 3; k++) write_reg_port(REG_DATA_END + 3'(k), rand64());
    program_run(64'd100, 64'd10, 64'd1000, 13'd4, 32'd500);
    load_entry(0, 64'd10, 32'd0);
    load_entry(1, 64'd20, 32'd100);
    load_entry(2, 64'd30, 32'd200);
    load_entry(3, 64'd1000, 32'd300);
    load_entry(ENTRIES - 1, KEY_MAX, 32'hFFFF_FFFF);
    query_key(64'd10, 64'd0);
    query_key(64'd1000, 64'd99);
    query_key(64'd20, 64'd5);
    query_key(64'd25, 64'd1);
    query_key(64'd9, 64'd0);
    query_key(64'd1001, 64'd0);
    query_key(KEY_MAX, 64'd0);
    query_key(64'd10, 64'd100);
    query_key(64'd10, KEY_MAX);
    // offsets out of order: lengths wrap
    load_entry(2, 64'd30, 32'd50);
    query_key(64'd20, 64'd0);
    query_key(64'd30, 64'd0);
    wait_until_drained();
    // empty run
    program_run(64'd100, 64'd10, 64'd1000, 13'd0, 32'd500);
    query_key(64'd20, 64'd0);
    wait_until_drained();
    program_run(KEY_MAX, 64'd0, KEY_MAX, 13'd1, 32'd0);
    load_entry(0, 64'd0, 32'h0000_1234);
    query_key(64'd0, KEY_MAX - 64'd1);
    query_key(KEY_MAX, 64'd0);
    query_key(64'd0, KEY_MAX);
    wait_until_drained();

    for (int p = 0; p < 10; p++) begin
      if (p == 5) run_full_phase(ENTRIES);
      else if (p == 6) run_full_phase(8191);
      else run_phase(p);
    end

    wait_until_drained();
    repeat (20) @(posedge clk);
    if (sb.error_count == 0 && sb.pending_answers.size() == 0)
      $display("** sorted_run_key_lookup_core: PASSED **");
    else
      $display("** sorted_run_key_lookup_core: FAILED **");
    $finish;
  end

endmodule
